FILE: rtl/core/tew_pkg.sv
// shared types, constants and helpers of the triangle edge walker
package tew_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int NUM_ATTR   = 5;
   localparam int ATTR_IDX_W = 3;
   localparam int CSR_IDX_W  = 3;
   // divider works on |x span| << FRAC_BITS over a 33 bit y span
   localparam int SPAN_W     = 33;
   localparam int DIV_W      = SPAN_W + FRAC_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_W);
   localparam int PROD_W     = 2 * SPAN_W;
   localparam int SAT_W      = PROD_W + 2;
   localparam int REQ_DATA_W = 9 * 32;
   localparam int RSP_DATA_W = 6 * 32 + 2 * 16;

   typedef enum logic [1:0] {
      MUL_YPRE_SLOPE,
      MUL_GX_XPRE,
      MUL_GY_YPRE,
      MUL_GX_SLOPE
   } mul_sel_type;

   typedef struct packed {
      logic                  load;
      logic                  div_step;
      logic                  slope_wr;
      logic                  mul_en;
      mul_sel_type           mul_sel;
      logic                  newx_wr;
      logic                  hold_wr;
      logic                  val_wr;
      logic                  step_wr;
      logic                  row_step;
      logic                  out_load;
      logic [ATTR_IDX_W-1:0] attr_idx;
   } dp_cmd_type;

   typedef struct packed {
      logic rsp_pending;
   } dp_status_type;

   // clamp a wide signed value to the signed 32 bit range
   function automatic logic [31:0] sat32(input logic signed [SAT_W-1:0] v);
      logic [31:0] r;
      if (&v[SAT_W-1:31] || ~|v[SAT_W-1:31]) begin
         r = v[31:0];
      end else if (v[SAT_W-1]) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'h7fff_ffff;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/tew_ctrl.sv
// sequencer for edge setup and row stepping
module tew_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_kind,
   input  logic                   rsp_tready,
   input  tew_pkg::dp_status_type status,
   output tew_pkg::dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV, ST_SLOPE, ST_MULX, ST_NEWX,
      ST_MA1, ST_MA2, ST_MA3, ST_MA4, ST_DONE
   } state_type;

   state_type                       state_ff, state_in;
   logic [tew_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [tew_pkg::ATTR_IDX_W-1:0]  idx_ff, idx_in;
   logic                            accept;
   logic                            out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !status.rsp_pending || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      cmd          = '0;
      cmd.mul_sel  = tew_pkg::MUL_YPRE_SLOPE;
      cmd.attr_idx = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind) begin
                  cmd.row_step = 1'b1;
                  state_in     = ST_DONE;
               end else begin
                  cmd.load = 1'b1;
                  cnt_in   = '0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == tew_pkg::DIV_CNT_W'(tew_pkg::DIV_W - 1)) begin
               state_in = ST_SLOPE;
            end
         end
         ST_SLOPE: begin
            cmd.slope_wr = 1'b1;
            state_in     = ST_MULX;
         end
         ST_MULX: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = tew_pkg::MUL_YPRE_SLOPE;
            state_in    = ST_NEWX;
         end
         ST_NEWX: begin
            cmd.newx_wr = 1'b1;
            idx_in      = '0;
            state_in    = ST_MA1;
         end
         ST_MA1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = tew_pkg::MUL_GX_XPRE;
            state_in    = ST_MA2;
         end
         ST_MA2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = tew_pkg::MUL_GY_YPRE;
            cmd.hold_wr = 1'b1;
            state_in    = ST_MA3;
         end
         ST_MA3: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = tew_pkg::MUL_GX_SLOPE;
            cmd.val_wr  = 1'b1;
            state_in    = ST_MA4;
         end
         ST_MA4: begin
            cmd.step_wr = 1'b1;
            if (idx_ff == tew_pkg::ATTR_IDX_W'(tew_pkg::NUM_ATTR - 1)) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_MA1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

FILE: rtl/core/tew_datapath.sv
// edge state, divider, shared multiplier and result register
module tew_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tew_pkg::dp_cmd_type                   cmd,
   output tew_pkg::dp_status_type                status,
   input  logic [tew_pkg::REQ_DATA_W-1:0]        req_tdata,
   input  logic                                  csr_valid,
   input  logic                                  csr_ready,
   input  logic [tew_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [63:0]                           csr_wdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [tew_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                  rsp_tuser
);

   localparam int F = tew_pkg::FRAC_BITS;
   localparam int W = tew_pkg::SAT_W;

   // configuration and edge state
   logic [63:0]        grad_ff [tew_pkg::NUM_ATTR];
   logic [31:0]        val_ff  [tew_pkg::NUM_ATTR];
   logic [31:0]        step_ff [tew_pkg::NUM_ATTR];
   logic [31:0]        a0_ff   [tew_pkg::NUM_ATTR];
   logic [31:0]        cur_x_ff, slope_ff;
   logic [15:0]        row0_ff, row1_ff;
   logic               flat_ff, flat_pend_ff;

   // setup working registers
   logic signed [31:0] sx_ff;
   logic [F-1:0]       ypre_ff;
   logic signed [32:0] xpre_ff;
   logic               neg_ff;
   logic [32:0]        divisor_ff, rem_ff;
   logic [tew_pkg::DIV_W-1:0] quo_ff;
   logic signed [tew_pkg::PROD_W-1:0] prod_ff, hold_ff;

   // result register
   logic               rsp_valid_ff;
   logic [tew_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic               rsp_user_ff;

   logic signed [31:0] in_sx, in_sy, in_fx, in_fy;
   logic signed [32:0] xd, yd;
   logic [32:0]        abs_xd, abs_yd;
   logic signed [63:0] row0_sum, row1_sum;
   logic [31:0]        neg_sy;
   logic [33:0]        rem_sh, diff;
   logic               qbit;
   logic [31:0]        slope_val;
   logic signed [32:0] mul_a, mul_b;
   logic signed [tew_pkg::PROD_W-1:0] product;
   logic signed [31:0] gx, gy;
   logic [31:0]        nx;
   logic signed [tew_pkg::PROD_W:0] pair_sum;
   logic [31:0]        val_new, step_new;

   assign in_sx = req_tdata[31:0];
   assign in_sy = req_tdata[63:32];
   assign in_fx = req_tdata[95:64];
   assign in_fy = req_tdata[127:96];

   assign xd     = 33'(in_fx) - 33'(in_sx);
   assign yd     = 33'(in_fy) - 33'(in_sy);
   assign abs_xd = xd[32] ? 33'(-xd) : xd;
   assign abs_yd = yd[32] ? 33'(-yd) : yd;
   assign row0_sum = 64'(in_sy) + 64'((64'd1 << F) - 64'd1);
   assign row1_sum = 64'(in_fy) + 64'((64'd1 << F) - 64'd1);
   assign neg_sy   = 32'd0 - in_sy;

   // restoring divider, one quotient bit a cycle
   assign rem_sh = {rem_ff, quo_ff[tew_pkg::DIV_W-1]};
   assign diff   = rem_sh - {1'b0, divisor_ff};
   assign qbit   = !diff[33];

   always_comb begin
      if (flat_pend_ff) begin
         slope_val = '0;
      end else if (neg_ff) begin
         if (|quo_ff[tew_pkg::DIV_W-1:32] || (quo_ff[31] && |quo_ff[30:0])) begin
            slope_val = 32'h8000_0000;
         end else begin
            slope_val = 32'd0 - quo_ff[31:0];
         end
      end else if (|quo_ff[tew_pkg::DIV_W-1:31]) begin
         slope_val = 32'h7fff_ffff;
      end else begin
         slope_val = quo_ff[31:0];
      end
   end

   assign gx = grad_ff[cmd.attr_idx][31:0];
   assign gy = grad_ff[cmd.attr_idx][63:32];

   always_comb begin
      unique case (cmd.mul_sel)
         tew_pkg::MUL_YPRE_SLOPE: begin
            mul_a = 33'(signed'(slope_ff));
            mul_b = signed'(33'(ypre_ff));
         end
         tew_pkg::MUL_GX_XPRE: begin
            mul_a = 33'(gx);
            mul_b = xpre_ff;
         end
         tew_pkg::MUL_GY_YPRE: begin
            mul_a = 33'(gy);
            mul_b = signed'(33'(ypre_ff));
         end
         tew_pkg::MUL_GX_SLOPE: begin
            mul_a = 33'(gx);
            mul_b = 33'(signed'(slope_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product  = mul_a * mul_b;
   assign nx       = tew_pkg::sat32(W'(sx_ff) + W'(prod_ff >>> F));
   assign pair_sum = (tew_pkg::PROD_W + 1)'(hold_ff) + (tew_pkg::PROD_W + 1)'(prod_ff);
   assign val_new  = tew_pkg::sat32(W'(signed'(a0_ff[cmd.attr_idx])) + W'(pair_sum >>> F));
   assign step_new = tew_pkg::sat32(W'(gy) + W'(prod_ff >>> F));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tew_pkg::NUM_ATTR; i++) begin
            grad_ff[i] <= '0;
            val_ff[i]  <= '0;
            step_ff[i] <= '0;
         end
         cur_x_ff     <= '0;
         slope_ff     <= '0;
         row0_ff      <= '0;
         row1_ff      <= '0;
         flat_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready &&
             csr_index < tew_pkg::CSR_IDX_W'(tew_pkg::NUM_ATTR)) begin
            grad_ff[csr_index] <= csr_wdata;
         end
         if (cmd.load) begin
            row0_ff <= row0_sum[F +: 16];
            row1_ff <= row1_sum[F +: 16];
         end
         if (cmd.slope_wr) begin
            slope_ff <= slope_val;
            flat_ff  <= flat_pend_ff;
         end
         if (cmd.newx_wr) begin
            cur_x_ff <= nx;
         end
         if (cmd.val_wr) begin
            val_ff[cmd.attr_idx] <= val_new;
         end
         if (cmd.step_wr) begin
            step_ff[cmd.attr_idx] <= step_new;
         end
         if (cmd.row_step) begin
            cur_x_ff <= cur_x_ff + slope_ff;
            for (int i = 0; i < tew_pkg::NUM_ATTR; i++) begin
               val_ff[i] <= val_ff[i] + step_ff[i];
            end
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sx_ff        <= in_sx;
         ypre_ff      <= neg_sy[F-1:0];
         neg_ff       <= xd[32] ^ yd[32];
         flat_pend_ff <= (yd == '0);
         divisor_ff   <= abs_yd;
         rem_ff       <= '0;
         quo_ff       <= {abs_xd, {F{1'b0}}};
         for (int i = 0; i < tew_pkg::NUM_ATTR; i++) begin
            a0_ff[i] <= req_tdata[128 + 32 * i +: 32];
         end
      end
      if (cmd.div_step) begin
         rem_ff <= qbit ? diff[32:0] : rem_sh[32:0];
         quo_ff <= {quo_ff[tew_pkg::DIV_W-2:0], qbit};
      end
      if (cmd.mul_en) begin
         prod_ff <= product;
      end
      if (cmd.hold_wr) begin
         hold_ff <= prod_ff;
      end
      if (cmd.newx_wr) begin
         xpre_ff <= 33'(signed'(nx)) - 33'(sx_ff);
      end
      if (cmd.out_load) begin
         rsp_data_ff <= {row1_ff, row0_ff, val_ff[4], val_ff[3], val_ff[2],
                         val_ff[1], val_ff[0], cur_x_ff};
         rsp_user_ff <= flat_ff;
      end
   end

   assign status.rsp_pending = rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

FILE: rtl/core/triangle_edge_walker_top.sv
// triangle edge walker: edge setup with sub-pixel prestep and row stepping
// step transaction: row step on acceptance, result load once the output is free;
// setup: DIV_W quotient bits, slope write, x prestep and ST_MA1 to ST_MA4 per
// attribute on the shared multiplier, then the result load; no new request is taken
// before that load, but one is taken while a result waits in the output register;
// synchronous active-high reset clears gradients, edge state and the output
module triangle_edge_walker_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // start_x, start_y, finish_x, finish_y, start_tex_u, start_tex_v,
   // start_recip_z, start_depth, start_light
   input  logic [tew_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // edge_x, tex_u, tex_v, recip_z, depth_value, light_value, first_row, last_row
   output logic [tew_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // flat_edge
   output logic                             rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tew_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [63:0]                      csr_wdata
);

   tew_pkg::dp_cmd_type    cmd;
   tew_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   tew_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tew_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
